[hdl/rvva_pkg.sv]
// ----------------------------------------------------------------------------
// rvva_pkg
// Shared types and constants for the rail voltage vote arbiter.
// ----------------------------------------------------------------------------
package rvva_pkg;

  localparam int NUM_USERS     = 6;
  localparam int TABLE_ENTRIES = 4;
  localparam int VOLT_WIDTH    = 16;

  localparam int CODE_W        = 8;
  localparam int CODE_MAX_PINS = 8;
  localparam int TSIZE_W       = 3;
  localparam int PINS_W        = 4;
  localparam int ENTRY_W       = 24;
  localparam int CFG_DATA_W    = ENTRY_W;

  // register indexes
  localparam int CFG_VOTE_MODE  = 0;
  localparam int CFG_TABLE_SIZE = 1;
  localparam int CFG_PIN_COUNT  = 2;
  localparam int CFG_ENTRY_BASE = 3;
  localparam int CFG_IDX_W      = $clog2(CFG_ENTRY_BASE + TABLE_ENTRIES);

  localparam logic VOTE_MAX     = 1'b0;
  localparam logic VOTE_MIN_POS = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_IDX = 1'b1;

  typedef enum logic [1:0] {
    FUNC_SET     = 2'd0,
    FUNC_ENABLE  = 2'd1,
    FUNC_DISABLE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [2:0]            user_index;
    logic [VOLT_WIDTH-1:0] voltage;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [VOLT_WIDTH-1:0] voted_voltage;
    logic [CODE_W-1:0]     select_code;
    logic                  rail_enable;
  } out_item_t;

  typedef struct packed {
    logic                                  vote_mode;
    logic [TSIZE_W-1:0]                    table_size;
    logic [PINS_W-1:0]                     pin_count;
    logic [TABLE_ENTRIES-1:0][ENTRY_W-1:0] table_entry;
  } cfg_t;

endpackage

[hdl/rail_voltage_vote_arbiter.sv]
// ----------------------------------------------------------------------------
// rail_voltage_vote_arbiter
// Arbitrates one power rail among several users and drives the select code.
// ----------------------------------------------------------------------------
// One request can be taken every clock cycle as long as results are taken as
// fast. A request register feeds a single update stage that applies the
// request to the user votes, takes the vote and looks up the threshold table.
// The result goes into an output register. It is offered once the request
// has passed the request register and moved into the output register.
// While a result waits, one more request can wait in the request register.
// in_stall rises only when both registers are full and out_stall is high.
// Every request sees the state left by the one before it. The user must
// write configuration via the cfg_ port only while idle; no check is made.
module rail_voltage_vote_arbiter import rvva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  in_item_t  s1_item_r;
  logic      s1_valid_r, s1_valid_nxt;
  out_item_t out_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t result;
  logic      s1_go;
  logic      in_take;

  rvva_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rvva_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .go     (s1_go),
    .item   (s1_item_r),
    .result (result)
  );

  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_go ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_item_r <= in_data;
    if (s1_go)   out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // an advancing request always lands in the output register
  a_go_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("advanced request lost");

  // a blocked request stays put
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("blocked request dropped or changed");

  // request stage only advances into a free or draining output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

endmodule

[hdl/rvva_cfg.sv]
// ----------------------------------------------------------------------------
// rvva_cfg
// Configuration register file: vote mode, table size, pin count, thresholds.
// ----------------------------------------------------------------------------
module rvva_cfg import rvva_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      if (32'(cfg_index) == CFG_VOTE_MODE) begin
        cfg_nxt.vote_mode = cfg_wdata[0];
      end
      if (32'(cfg_index) == CFG_TABLE_SIZE) begin
        cfg_nxt.table_size = cfg_wdata[TSIZE_W-1:0];
      end
      if (32'(cfg_index) == CFG_PIN_COUNT) begin
        cfg_nxt.pin_count = cfg_wdata[PINS_W-1:0];
      end
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (32'(cfg_index) == CFG_ENTRY_BASE + k) begin
          cfg_nxt.table_entry[k] = cfg_wdata[ENTRY_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/rvva_core.sv]
// ----------------------------------------------------------------------------
// rvva_core
// Per-user vote state, vote reduction and threshold lookup; commits on go.
// ----------------------------------------------------------------------------
module rvva_core import rvva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      go,
  input  in_item_t  item,
  output out_item_t result
);

  logic [NUM_USERS-1:0][VOLT_WIDTH-1:0] user_volt_r, user_volt_nxt;
  logic [NUM_USERS-1:0]                 active_r, active_nxt;
  logic [VOLT_WIDTH-1:0]                voted_r, voted_nxt;
  logic [CODE_W-1:0]                    code_r, code_nxt;
  logic                                 enable_r, enable_nxt;

  logic                  idx_ok;
  logic                  revote;
  logic [VOLT_WIDTH-1:0] acc;
  logic [VOLT_WIDTH-1:0] v;
  logic [TSIZE_W-1:0]    n_ent;
  logic [PINS_W-1:0]     n_pins;
  logic [CODE_W-1:0]     code_sel;
  logic [CODE_W-1:0]     pin_mask;

  assign idx_ok = 32'(item.user_index) < NUM_USERS;

  // state update for this request
  always_comb begin
    user_volt_nxt = user_volt_r;
    active_nxt    = active_r;
    enable_nxt    = enable_r;
    revote        = 1'b0;
    if (idx_ok) begin
      unique case (item.func)
        FUNC_SET: begin
          for (int u = 0; u < NUM_USERS; u++) begin
            if (32'(item.user_index) == u) user_volt_nxt[u] = item.voltage;
          end
          revote = 1'b1;
        end
        FUNC_ENABLE: begin
          for (int u = 0; u < NUM_USERS; u++) begin
            if (32'(item.user_index) == u) active_nxt[u] = 1'b1;
          end
          enable_nxt = 1'b1;
        end
        FUNC_DISABLE: begin
          for (int u = 0; u < NUM_USERS; u++) begin
            if (32'(item.user_index) == u) begin
              active_nxt[u]    = 1'b0;
              user_volt_nxt[u] = '0;
            end
          end
          revote = 1'b1;
          if (active_nxt == '0) enable_nxt = 1'b0;
        end
        FUNC_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // vote over active users, after this request's update
  always_comb begin
    acc = '0;
    v   = '0;
    for (int u = 0; u < NUM_USERS; u++) begin
      v = user_volt_nxt[u];
      if (active_nxt[u]) begin
        if (cfg.vote_mode == VOTE_MIN_POS) begin
          if (acc == '0 || (v != '0 && v < acc)) acc = v;
        end else if (v > acc) begin
          acc = v;
        end
      end
    end
  end

  // threshold search: first entry at or above the level, else last in use
  always_comb begin
    n_ent    = (32'(cfg.table_size) > TABLE_ENTRIES) ? TSIZE_W'(TABLE_ENTRIES)
                                                     : cfg.table_size;
    n_pins   = (32'(cfg.pin_count) > CODE_MAX_PINS) ? PINS_W'(CODE_MAX_PINS)
                                                    : cfg.pin_count;
    code_sel = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (32'(n_ent) == k + 1) code_sel = cfg.table_entry[k][23:16];
    end
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (32'(n_ent) > k && acc <= cfg.table_entry[k][15:0]) begin
        code_sel = cfg.table_entry[k][23:16];
      end
    end
    for (int b = 0; b < CODE_W; b++) begin
      pin_mask[b] = 32'(n_pins) > b;
    end
  end

  always_comb begin
    voted_nxt = voted_r;
    code_nxt  = code_r;
    if (revote) begin
      voted_nxt = acc;
      if (n_ent != '0 && n_pins != '0) code_nxt = code_sel & pin_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      user_volt_r <= '0;
      active_r    <= '0;
      voted_r     <= '0;
      code_r      <= '0;
      enable_r    <= 1'b0;
    end else if (go) begin
      user_volt_r <= user_volt_nxt;
      active_r    <= active_nxt;
      voted_r     <= voted_nxt;
      code_r      <= code_nxt;
      enable_r    <= enable_nxt;
    end
  end

  assign result.status        = idx_ok ? STATUS_OK : STATUS_BAD_IDX;
  assign result.voted_voltage = voted_nxt;
  assign result.select_code   = code_nxt;
  assign result.rail_enable   = enable_nxt;

  // any active user keeps the rail on
  a_active_rail_on: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r != '0) |-> enable_r)
    else $error("active user with rail off");

  // with nobody active the vote can only be zero
  a_idle_vote_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == '0) |-> (voted_r == '0))
    else $error("nonzero vote with no active user");

  // a rejected request leaves the state alone
  a_bad_idx_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !idx_ok) |=> ($stable(user_volt_r) && $stable(active_r) &&
                         $stable(voted_r) && $stable(code_r) && $stable(enable_r)))
    else $error("rejected request changed state");

endmodule
